>>> hdl/descriptor_free_list_allocator_defines.svh
// Assertion macros for the allocator top level.
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define DFLA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("dfla assertion failed");
`define DFLA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dfla assertion failed");
`else
`define DFLA_ASSERT(lbl, clk, rst_n, prop)
`define DFLA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/dfla_pkg.sv
package dfla_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int HEAP_W     = 8;
    localparam int CAP_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CAP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAP = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(POOL_DEPTH);

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_FOREIGN   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_stack_port;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_map_port;

endpackage

>>> hdl/dfla_ram.sv
module dfla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dfla_ctrl.sv
module dfla_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [dfla_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [dfla_pkg::HEAP_W-1:0]     i_handle_heap_id,
    input  logic                            i_cfg_we,
    input  logic [dfla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfla_pkg::CFG_W-1:0]      i_cfg_wdata,
    output dfla_pkg::t_stack_port           o_stack,
    input  logic [dfla_pkg::SLOT_W-1:0]     i_stack_rdata,
    output dfla_pkg::t_map_port             o_map,
    input  logic                            i_map_rdata,
    output logic                            o_valid,
    output logic [dfla_pkg::SLOT_W-1:0]     o_granted_index,
    output logic [2:0]                      o_status
);

    import dfla_pkg::*;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SLOT_W-1:0]   r_bump, n_bump;
    logic [CNT_W-1:0]    r_cap;
    logic [HEAP_W-1:0]   r_heap;
    t_func               r_func;
    logic [SLOT_W-1:0]   r_slot;
    logic [HEAP_W-1:0]   r_hid;
    logic                r_valid, n_valid;
    logic [SLOT_W-1:0]   r_granted, n_granted;
    t_status             r_status, n_status;

    logic                accept;
    logic [CNT_W-1:0]    bump_next;
    logic [CNT_W-1:0]    cap_eff;

    assign accept    = start && (r_state == S_IDLE);
    assign bump_next = {1'b0, r_bump} + CNT_W'(1);

    // Capacity is clamped to 1..POOL_DEPTH when it is written.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(POOL_DEPTH)) begin
            cap_eff = CNT_W'(POOL_DEPTH);
        end else begin
            cap_eff = CNT_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == SLOT_W'(POOL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_bump     = r_bump;
        n_valid    = 1'b0;
        n_granted  = '0;
        n_status   = ST_OK;

        // Reads are issued on the accepting edge; data is ready in the execute cycle.
        o_stack.we    = 1'b0;
        o_stack.waddr = r_count[SLOT_W-1:0];
        o_stack.wdata = r_slot;
        o_stack.re    = accept;
        o_stack.raddr = SLOT_W'(r_count - CNT_W'(1));

        o_map.we    = 1'b0;
        o_map.waddr = r_slot;
        o_map.wdata = 1'b0;
        o_map.re    = accept;
        o_map.raddr = i_slot_index;

        unique case (r_state)
            S_CLEAR: begin
                o_map.we    = 1'b1;
                o_map.waddr = r_clr_addr;
                o_map.wdata = 1'b0;
                n_clr_addr  = r_clr_addr + SLOT_W'(1);
            end
            S_IDLE: begin
            end
            S_EXEC: begin
                n_valid = 1'b1;
                if (r_func == FN_ALLOC) begin
                    if (r_count != '0) begin
                        o_map.we    = 1'b1;
                        o_map.waddr = i_stack_rdata;
                        o_map.wdata = 1'b0;
                        n_count     = r_count - CNT_W'(1);
                        n_granted   = i_stack_rdata;
                    end else if (bump_next < r_cap) begin
                        n_bump    = bump_next[SLOT_W-1:0];
                        n_granted = bump_next[SLOT_W-1:0];
                    end else begin
                        n_status = ST_EXHAUSTED;
                    end
                end else begin
                    if ((r_hid != r_heap) || ({1'b0, r_slot} >= r_cap)) begin
                        n_status = ST_FOREIGN;
                    end else if (i_map_rdata) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_count >= CNT_W'(POOL_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_stack.we  = 1'b1;
                        o_map.we    = 1'b1;
                        o_map.wdata = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_bump     <= '0;
            r_cap      <= CAP_RESET;
            r_heap     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_bump     <= n_bump;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CAP:  r_cap  <= cap_eff;
                    REG_HEAP: r_heap <= i_cfg_wdata[HEAP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_slot <= i_slot_index;
            r_hid  <= i_handle_heap_id;
        end
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;

endmodule

>>> hdl/descriptor_free_list_allocator.sv
// Channel    Direction  Handshake            Payload
// request    in         start, busy          i_func, i_slot_index, i_handle_heap_id
// result     out        o_valid (strobe)     o_granted_index, o_status
// config     in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// A request is taken only while idle: the accepting edge reads the free stack
// and the membership map, and the next cycle modifies and writes them back;
// busy is high meanwhile, so a new request waits until the last is done. The
// result strobe comes in the cycle after the execute cycle and lasts one cycle;
// the receiver cannot stall. After reset the membership map is cleared one entry
// a cycle, during which busy stays high.
`include "descriptor_free_list_allocator_defines.svh"

module descriptor_free_list_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [dfla_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [dfla_pkg::HEAP_W-1:0]     i_handle_heap_id,
    input  logic                            i_cfg_we,
    input  logic [dfla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfla_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                            o_valid,
    output logic [dfla_pkg::SLOT_W-1:0]     o_granted_index,
    output logic [2:0]                      o_status
);

    import dfla_pkg::*;

    t_stack_port        stack_port;
    t_map_port          map_port;
    logic [SLOT_W-1:0]  stack_rdata;
    logic               map_rdata;

    dfla_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_slot_index     (i_slot_index),
        .i_handle_heap_id (i_handle_heap_id),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_stack          (stack_port),
        .i_stack_rdata    (stack_rdata),
        .o_map            (map_port),
        .i_map_rdata      (map_rdata),
        .o_valid          (o_valid),
        .o_granted_index  (o_granted_index),
        .o_status         (o_status)
    );

    // LIFO of freed indices.
    dfla_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_port.we),
        .i_waddr (stack_port.waddr),
        .i_wdata (stack_port.wdata),
        .i_re    (stack_port.re),
        .i_raddr (stack_port.raddr),
        .o_rdata (stack_rdata)
    );

    // One bit per index: set while the index sits on the free stack.
    dfla_ram #(
        .WIDTH (1),
        .DEPTH (POOL_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_port.we),
        .i_waddr (map_port.waddr),
        .i_wdata (map_port.wdata),
        .i_re    (map_port.re),
        .i_raddr (map_port.raddr),
        .o_rdata (map_rdata)
    );

    `DFLA_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> (busy && !o_valid))
    `DFLA_ASSERT(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid)
    `DFLA_ASSERT(a_fail_no_grant, i_clk, i_rst_n,
        (o_valid && (o_status != ST_OK)) |-> (o_granted_index == '0))
    `DFLA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (busy && !o_valid))

endmodule
